// File: src/fjsp_pkg.sv
// ----------------------------------------------------------------------------
// fjsp_pkg
// Shared types and constants for the flat JSON string object parser: parse
// phases, result kinds, character codes and the parser state record.
// ----------------------------------------------------------------------------
package fjsp_pkg;

	// parse phases
	typedef enum logic [3:0] {
		PH_OPEN      = 4'd0,
		PH_KEY_OR_CL = 4'd1,
		PH_STRING    = 4'd2,
		PH_ESCAPE    = 4'd3,
		PH_HEX       = 4'd4,
		PH_COLON     = 4'd5,
		PH_VALUE     = 4'd6,
		PH_SEP       = 4'd7,
		PH_FINISHED  = 4'd8
	} phase_t;

	// result kinds
	typedef enum logic [2:0] {
		K_KEY_BYTE = 3'd0,
		K_VAL_BYTE = 3'd1,
		K_KEY_END  = 3'd2,
		K_VAL_END  = 3'd3,
		K_DONE     = 3'd4,
		K_ERROR    = 3'd5
	} kind_t;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_U   = 8'h75;

	// number of hex digits skipped after a unicode escape
	localparam logic [2:0] HEX_DIGITS = 3'd4;

	// parser state carried from item to item
	typedef struct packed {
		phase_t     phase;
		logic       in_value;
		logic [2:0] hex_left;
	} pstate_t;

	// result of one parser step
	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		kind_t      kind;
	} presult_t;

endpackage

// File: src/fjsp_step.sv
// ----------------------------------------------------------------------------
// fjsp_step
// Combinational parser step: from the current state and one text byte it
// forms the next state and at most one result.
// ----------------------------------------------------------------------------
module fjsp_step
	import fjsp_pkg::*;
(
	input  logic [7:0] text_byte,
	input  pstate_t    cur,
	output pstate_t    nxt,
	output presult_t   res
);

	logic       is_space;
	logic       is_nul;
	logic [7:0] esc_byte;
	kind_t      str_kind;
	logic [2:0] hex_dec;

	// byte classes
	assign is_space = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
	                  (text_byte == CH_CR) || (text_byte == CH_LF);
	assign is_nul   = (text_byte == CH_NUL);
	assign str_kind = cur.in_value ? K_VAL_BYTE : K_KEY_BYTE;
	assign hex_dec  = (cur.hex_left != 3'd0) ? (cur.hex_left - 3'd1) : 3'd0;

	// escape decode
	always_comb begin
		case (text_byte)
			CH_LC_B: esc_byte = CH_BS;
			CH_LC_F: esc_byte = CH_FF;
			CH_LC_N: esc_byte = CH_LF;
			CH_LC_R: esc_byte = CH_CR;
			CH_LC_T: esc_byte = CH_TAB;
			CH_LC_U: esc_byte = CH_QMARK;
			default: esc_byte = text_byte;
		endcase
	end

	// next state and result
	always_comb begin
		logic fail;
		fail = 1'b0;
		nxt  = cur;
		res  = '{emit: 1'b0, data: 8'd0, kind: K_KEY_BYTE};
		unique case (cur.phase)
			PH_OPEN: begin
				if (text_byte == CH_LBRACE) nxt.phase = PH_KEY_OR_CL;
				else if (!is_space) fail = 1'b1;
			end
			PH_KEY_OR_CL: begin
				if (text_byte == CH_RBRACE) begin
					nxt.phase = PH_FINISHED;
					res = '{emit: 1'b1, data: 8'd0, kind: K_DONE};
				end else if (text_byte == CH_QUOTE) begin
					nxt.phase    = PH_STRING;
					nxt.in_value = 1'b0;
				end else if (!is_space) begin
					fail = 1'b1;
				end
			end
			PH_STRING: begin
				if (is_nul) begin
					fail = 1'b1;
				end else if (text_byte == CH_QUOTE) begin
					nxt.phase = cur.in_value ? PH_SEP : PH_COLON;
					res = '{emit: 1'b1, data: 8'd0,
					        kind: (cur.in_value ? K_VAL_END : K_KEY_END)};
				end else if (text_byte == CH_BSLASH) begin
					nxt.phase = PH_ESCAPE;
				end else begin
					res = '{emit: 1'b1, data: text_byte, kind: str_kind};
				end
			end
			PH_ESCAPE: begin
				if (is_nul) begin
					fail = 1'b1;
				end else begin
					if (text_byte == CH_LC_U) begin
						nxt.phase    = PH_HEX;
						nxt.hex_left = HEX_DIGITS;
					end else begin
						nxt.phase = PH_STRING;
					end
					res = '{emit: 1'b1, data: esc_byte, kind: str_kind};
				end
			end
			PH_HEX: begin
				if (is_nul) begin
					fail = 1'b1;
				end else begin
					nxt.hex_left = hex_dec;
					if (hex_dec == 3'd0) nxt.phase = PH_STRING;
				end
			end
			PH_COLON: begin
				if (text_byte == CH_COLON) nxt.phase = PH_VALUE;
				else if (!is_space) fail = 1'b1;
			end
			PH_VALUE: begin
				if (text_byte == CH_QUOTE) begin
					nxt.phase    = PH_STRING;
					nxt.in_value = 1'b1;
				end else if (!is_space) begin
					fail = 1'b1;
				end
			end
			PH_SEP: begin
				if (text_byte == CH_COMMA) begin
					nxt.phase = PH_KEY_OR_CL;
				end else if (text_byte == CH_RBRACE) begin
					nxt.phase = PH_FINISHED;
					res = '{emit: 1'b1, data: 8'd0, kind: K_DONE};
				end else if (!is_space) begin
					fail = 1'b1;
				end
			end
			default: begin
				// after done or error: wait for the end of text
				if (is_nul) begin
					nxt.phase    = PH_OPEN;
					nxt.hex_left = 3'd0;
				end else begin
					nxt.phase = PH_FINISHED;
				end
			end
		endcase

		// error path: a nul rearms at once, anything else waits for a nul
		if (fail) begin
			nxt.phase    = is_nul ? PH_OPEN : PH_FINISHED;
			nxt.hex_left = 3'd0;
			res = '{emit: 1'b1, data: 8'd0, kind: K_ERROR};
		end
	end

endmodule

// File: src/flat_json_string_object_parser_unit.sv
// ----------------------------------------------------------------------------
// flat_json_string_object_parser_unit
// Streaming tokenizer for a flat JSON object of string keys and values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one text byte per item. A zero
//   byte ends the text and rearms the parser after done or error.
//   Output channel: out_valid / out_stall carry decoded_byte and result_kind
//   (key byte, value byte, key end, value end, object done, error).
//   Every text ends in exactly one object done or error item.
//   Path: a byte that yields a result passes the input register and then the
//   result register on its way to the output.
//   Throughput: one byte per cycle while in_stall is low; the parser state
//   update is a single combinational step between the input and result registers.
//   Bytes that yield no result (whitespace, the opening brace, escape lead-ins)
//   pass the input register but put nothing on the output.
//   Reset: arst_n clears both registers' valid flags and sets the parser to
//   expect an opening brace.
//   Stall: a waiting result holds its register; the input register keeps
//   moving for bytes that yield no result, and in_stall rises only when a
//   result-producing byte is held behind a stalled result.
// ----------------------------------------------------------------------------
module flat_json_string_object_parser_unit
	import fjsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] decoded_byte,
	output logic [2:0] result_kind
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	pstate_t    state_q;
	pstate_t    state_nxt;
	presult_t   step_res;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	kind_t      out_kind_q;
	logic       slot_free;
	logic       s1_adv;
	logic       s1_fire;
	logic       in_fire;

	// handshake control
	assign slot_free = !out_valid_q || !out_stall;
	assign s1_adv    = !step_res.emit || slot_free;
	assign s1_fire   = valid_s1 && s1_adv;
	assign in_stall  = valid_s1 && !s1_adv;
	assign in_fire   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) byte_s1 <= text_byte;
	end

	// parser step
	fjsp_step u_step (
		.text_byte (byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (step_res)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_OPEN, in_value: 1'b0, hex_left: 3'd0};
		end else if (s1_fire) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && step_res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && step_res.emit) begin
			out_byte_q <= step_res.data;
			out_kind_q <= step_res.kind;
		end
	end

	assign out_valid    = out_valid_q;
	assign decoded_byte = out_byte_q;
	assign result_kind  = out_kind_q;

endmodule
